>>> design/relay_session_table_top_assert.svh
// Assertion macros for the relay session table.
// Used by relay_session_table_top; needs no other file.
`ifndef RELAY_SESSION_TABLE_TOP_ASSERT_SVH
`define RELAY_SESSION_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define RLST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RLST_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define RLST_ASSERT(lbl, clk, rst_n, prop, msg)
`define RLST_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

>>> design/rlst_pkg.sv
// Types and constants shared by the relay session table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rlst_pkg;

  localparam logic [15:0] LIMIT_RESET = 16'd100;

  typedef enum logic [2:0] {
    OUT_REGISTERED = 3'd0,
    OUT_FORWARD    = 3'd1,
    OUT_NO_SOURCE  = 3'd2,
    OUT_NO_PEER    = 3'd3,
    OUT_FULL       = 3'd4,
    OUT_IGNORED    = 3'd5
  } outcome_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP,
    S_APPEND,
    S_SRC,
    S_PEER,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] user;
    logic [31:0] device;
    logic        role;
    logic [31:0] address;
    logic [15:0] port;
  } entry_t;

endpackage

`default_nettype wire

>>> design/rlst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rlst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/relay_session_table_top.sv
// Relay session table: top level with sequencer and compare unit.
// Depends on rlst_pkg, rlst_ram and relay_session_table_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "relay_session_table_top_assert.svh"

// The block takes one datagram header at a time and holds in_stall high until it is done.
// Sessions live in one RAM that is scanned one entry per cycle through a single compare
// unit, so the time per item follows the number of stored sessions N: an ignored item
// needs no scan, a registration one scan, and a relayed datagram up to two scans
// (one for the source and one for its peer). The result waits in an output
// register, so the next item may start while a result is still stalled.
module relay_session_table_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_datagram_length,
  input  wire logic        in_init_tag,
  input  wire logic [31:0] in_user_ident,
  input  wire logic [31:0] in_device_ident,
  input  wire logic        in_role_is_device,
  input  wire logic [31:0] in_source_address,
  input  wire logic [15:0] in_source_port,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_outcome,
  output logic [31:0]      out_peer_address,
  output logic [15:0]      out_peer_port
);

  import rlst_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(entry_t);

  state_t      state_r, state_nxt;
  logic [15:0] limit_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] wr_idx_r, wr_idx_nxt;
  logic        chk_vld_r, chk_vld_nxt;
  logic [31:0] key_user_r, key_user_nxt;
  logic [31:0] key_dev_r, key_dev_nxt;
  logic        key_role_r, key_role_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [15:0] port_r, port_nxt;
  outcome_t    res_outcome_r, res_outcome_nxt;
  logic [31:0] res_addr_r, res_addr_nxt;
  logic [15:0] res_port_r, res_port_nxt;
  logic        out_valid_r;
  logic [2:0]  out_outcome_r;
  logic [31:0] out_addr_r;
  logic [15:0] out_port_r;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [EW-1:0] ram_rdata;
  entry_t        rd_ent;
  logic          issue, scan_end, key_hit, src_hit, peer_hit, out_load;

  rlst_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(EW'(ram_wdata)),
    .re   (ram_re),
    .raddr(rd_idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign rd_ent   = entry_t'(ram_rdata);
  assign issue    = rd_idx_r < cnt_r;
  assign scan_end = !issue && !chk_vld_r;
  assign key_hit  = (rd_ent.user == key_user_r) && (rd_ent.device == key_dev_r) &&
                    (rd_ent.role == key_role_r);
  assign src_hit  = (rd_ent.address == addr_r) && (rd_ent.port == port_r);
  assign peer_hit = (rd_ent.user == key_user_r) && (rd_ent.device == key_dev_r) &&
                    (rd_ent.role != key_role_r);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_outcome      = out_outcome_r;
  assign out_peer_address = out_addr_r;
  assign out_peer_port    = out_port_r;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    rd_idx_nxt      = rd_idx_r;
    wr_idx_nxt      = wr_idx_r;
    chk_vld_nxt     = 1'b0;
    key_user_nxt    = key_user_r;
    key_dev_nxt     = key_dev_r;
    key_role_nxt    = key_role_r;
    addr_nxt        = addr_r;
    port_nxt        = port_r;
    res_outcome_nxt = res_outcome_r;
    res_addr_nxt    = res_addr_r;
    res_port_nxt    = res_port_r;
    ram_re          = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = wr_idx_r[AW-1:0];
    ram_wdata       = rd_ent;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_user_nxt = in_user_ident;
          key_dev_nxt  = in_device_ident;
          key_role_nxt = in_role_is_device;
          addr_nxt     = in_source_address;
          port_nxt     = in_source_port;
          rd_idx_nxt   = '0;
          wr_idx_nxt   = '0;
          res_addr_nxt = '0;
          res_port_nxt = '0;
          if (in_datagram_length < limit_r) begin
            if (in_init_tag) begin
              state_nxt = S_DROP;
            end else begin
              res_outcome_nxt = OUT_IGNORED;
              state_nxt       = S_DONE;
            end
          end else begin
            state_nxt = S_SRC;
          end
        end
      end
      S_DROP: begin
        ram_re      = issue;
        chk_vld_nxt = issue;
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (chk_vld_r && !key_hit) begin
          ram_we     = 1'b1;
          wr_idx_nxt = wr_idx_r + 1'b1;
        end
        if (scan_end) begin
          cnt_nxt   = wr_idx_r;
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        if (cnt_r == CW'(TABLE_DEPTH)) begin
          res_outcome_nxt = OUT_FULL;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = cnt_r[AW-1:0];
          ram_wdata       = '{user: key_user_r, device: key_dev_r, role: key_role_r,
                              address: addr_r, port: port_r};
          cnt_nxt         = cnt_r + 1'b1;
          res_outcome_nxt = OUT_REGISTERED;
        end
        state_nxt = S_DONE;
      end
      S_SRC: begin
        ram_re      = issue;
        chk_vld_nxt = issue;
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (chk_vld_r && src_hit) begin
          key_user_nxt = rd_ent.user;
          key_dev_nxt  = rd_ent.device;
          key_role_nxt = rd_ent.role;
          rd_idx_nxt   = '0;
          chk_vld_nxt  = 1'b0;
          state_nxt    = S_PEER;
        end else if (scan_end) begin
          res_outcome_nxt = OUT_NO_SOURCE;
          state_nxt       = S_DONE;
        end
      end
      S_PEER: begin
        ram_re      = issue;
        chk_vld_nxt = issue;
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (chk_vld_r && peer_hit) begin
          res_outcome_nxt = OUT_FORWARD;
          res_addr_nxt    = rd_ent.address;
          res_port_nxt    = rd_ent.port;
          chk_vld_nxt     = 1'b0;
          state_nxt       = S_DONE;
        end else if (scan_end) begin
          res_outcome_nxt = OUT_NO_PEER;
          state_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= LIMIT_RESET;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      chk_vld_r <= chk_vld_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    wr_idx_r      <= wr_idx_nxt;
    key_user_r    <= key_user_nxt;
    key_dev_r     <= key_dev_nxt;
    key_role_r    <= key_role_nxt;
    addr_r        <= addr_nxt;
    port_r        <= port_nxt;
    res_outcome_r <= res_outcome_nxt;
    res_addr_r    <= res_addr_nxt;
    res_port_r    <= res_port_nxt;
    if (out_load) begin
      out_outcome_r <= res_outcome_r;
      out_addr_r    <= res_addr_r;
      out_port_r    <= res_port_r;
    end
  end

  `RLST_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CW'(TABLE_DEPTH), "entry count above depth")
  `RLST_ASSERT(a_drop_behind, clk, rst_n, (ram_we && state_r == S_DROP) |-> (wr_idx_r < rd_idx_r), "compaction write not behind read")
  `RLST_ASSERT(a_peer_zero, clk, rst_n, (out_valid_r && out_outcome_r != OUT_FORWARD) |-> (out_addr_r == '0 && out_port_r == '0), "peer fields set without forward")
  `RLST_ASSERT_NXT(a_cnt_step, clk, rst_n, 1'b1, {1'b0, cnt_r} <= {1'b0, $past(cnt_r)} + 1'b1, "entry count grew by more than one")

endmodule

`default_nettype wire
